// ----- design/fims_pkg.sv -----
`timescale 1ns / 1ps
// fims_pkg: types and constants shared by the flow inverse max splat core
// no dependencies

package fims_pkg;

  localparam int NUM_CORNERS = 4;
  localparam int DIM_W       = 8;
  localparam int COORD_W     = 12;
  localparam int FLOW_W      = 16;
  localparam int SCORE_W     = 24;
  localparam int PIX_W       = 14;
  localparam int CFG_IDX_W   = 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [FLOW_W-1:0]  flow_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [DIM_W-1:0]          dim_t;
  typedef logic [1:0]                corner_t;

  // request function codes
  localparam logic FUNC_SPLAT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;
  localparam dim_t CFG_DIM_RESET = 8'd128;

  // corner slots
  localparam corner_t CORNER_TL = 2'd0;
  localparam corner_t CORNER_TR = 2'd1;
  localparam corner_t CORNER_BR = 2'd2;
  localparam corner_t CORNER_BL = 2'd3;

  localparam flow_t  FLOW_MIN    = 16'sh8000;
  localparam flow_t  FLOW_MAX    = 16'sh7fff;
  // -10000.0 in Q15.8
  localparam score_t RESET_SCORE = -24'sd2560000;

  typedef struct packed {
    flow_t  fx;
    flow_t  fy;
    score_t score;
  } slot_t;

  localparam slot_t RESET_SLOT = '{fx: '0, fy: '0, score: RESET_SCORE};

  // classified request handed from front to back
  typedef struct packed {
    logic                         rd;
    logic                         in_image;
    score_t [NUM_CORNERS-1:0]     score;
    flow_t                        fx;
    flow_t                        fy;
  } cmd_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SPLAT,
    S_EMIT
  } state_t;

  // coordinate lies in 0..lim-1
  function automatic logic coord_ok(input coord_t c, input dim_t lim);
    return !c[COORD_W-1] && (c[COORD_W-2:0] < {3'b000, lim});
  endfunction

endpackage

// ----- design/flow_inverse_max_splat_core.sv -----
`timescale 1ns / 1ps
// flow_inverse_max_splat_core: in the back end a splat is a bank read, then a compare and
// write; a read is a bank read followed by four result slots, each held while out_stall is high.
// the front accepts a request in the cycle it arrives while the 2-entry queue has room.
// after reset a clearing pass writes MAX_WIDTH*MAX_HEIGHT rows with in_stall high;
// configuration writes are taken throughout.

module flow_inverse_max_splat_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fims_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fims_pkg::DIM_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [fims_pkg::COORD_W-1:0] in_left_x,
  input  logic signed [fims_pkg::COORD_W-1:0] in_right_x,
  input  logic signed [fims_pkg::COORD_W-1:0] in_top_y,
  input  logic signed [fims_pkg::COORD_W-1:0] in_bottom_y,
  input  logic signed [fims_pkg::SCORE_W-1:0] in_score_top_left,
  input  logic signed [fims_pkg::SCORE_W-1:0] in_score_top_right,
  input  logic signed [fims_pkg::SCORE_W-1:0] in_score_bottom_right,
  input  logic signed [fims_pkg::SCORE_W-1:0] in_score_bottom_left,
  input  logic signed [fims_pkg::FLOW_W-1:0]  in_motion_x,
  input  logic signed [fims_pkg::FLOW_W-1:0]  in_motion_y,
  input  logic [fims_pkg::PIX_W-1:0]          in_read_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_corner,
  output logic signed [fims_pkg::FLOW_W-1:0]  out_motion_x,
  output logic signed [fims_pkg::FLOW_W-1:0]  out_motion_y,
  output logic signed [fims_pkg::SCORE_W-1:0] out_score,
  output logic                                out_last
);
  import fims_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int QW = $bits(cmd_t) + NUM_CORNERS * AW;

  logic keep, push, q_full, q_valid, pop, clearing;
  cmd_t f_cmd, q_cmd;
  logic [NUM_CORNERS-1:0][AW-1:0] f_addr, q_addr;
  logic [QW-1:0] q_din, q_dout;

  assign in_stall = clearing || q_full;
  // footprints outside the image are dropped here
  assign push     = in_valid && !in_stall && keep;
  assign q_din    = {f_cmd, f_addr};
  assign {q_cmd, q_addr} = q_dout;

  fims_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_func              (in_func),
    .in_left_x            (in_left_x),
    .in_right_x           (in_right_x),
    .in_top_y             (in_top_y),
    .in_bottom_y          (in_bottom_y),
    .in_score_top_left    (in_score_top_left),
    .in_score_top_right   (in_score_top_right),
    .in_score_bottom_right(in_score_bottom_right),
    .in_score_bottom_left (in_score_bottom_left),
    .in_motion_x          (in_motion_x),
    .in_motion_y          (in_motion_y),
    .in_read_pixel        (in_read_pixel),
    .keep_o               (keep),
    .cmd_o                (f_cmd),
    .addr_o               (f_addr)
  );

  fims_fifo #(
    .DW(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .din     (q_din),
    .full    (q_full),
    .pop     (pop),
    .nonempty(q_valid),
    .dout    (q_dout)
  );

  fims_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_addr      (q_addr),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_corner  (out_corner),
    .out_motion_x(out_motion_x),
    .out_motion_y(out_motion_y),
    .out_score   (out_score),
    .out_last    (out_last)
  );

endmodule

// ----- design/fims_front.sv -----
`timescale 1ns / 1ps
// fims_front: configuration registers, bounds test and address generation
// depends on fims_pkg

module fims_front #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int AW         = 14
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [fims_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [fims_pkg::DIM_W-1:0]                  cfg_data,
  input  logic                                        in_func,
  input  logic signed [fims_pkg::COORD_W-1:0]         in_left_x,
  input  logic signed [fims_pkg::COORD_W-1:0]         in_right_x,
  input  logic signed [fims_pkg::COORD_W-1:0]         in_top_y,
  input  logic signed [fims_pkg::COORD_W-1:0]         in_bottom_y,
  input  logic signed [fims_pkg::SCORE_W-1:0]         in_score_top_left,
  input  logic signed [fims_pkg::SCORE_W-1:0]         in_score_top_right,
  input  logic signed [fims_pkg::SCORE_W-1:0]         in_score_bottom_right,
  input  logic signed [fims_pkg::SCORE_W-1:0]         in_score_bottom_left,
  input  logic signed [fims_pkg::FLOW_W-1:0]          in_motion_x,
  input  logic signed [fims_pkg::FLOW_W-1:0]          in_motion_y,
  input  logic [fims_pkg::PIX_W-1:0]                  in_read_pixel,
  output logic                                        keep_o,
  output fims_pkg::cmd_t                              cmd_o,
  output logic [fims_pkg::NUM_CORNERS-1:0][AW-1:0]    addr_o
);
  import fims_pkg::*;

  localparam int CW = (AW > 16) ? AW : 16;
  localparam logic [11:0] MAXW = 12'(MAX_WIDTH);
  localparam logic [11:0] MAXH = 12'(MAX_HEIGHT);

  dim_t width_r, height_r;
  dim_t w_eff, h_eff;
  logic bounds_ok, rd_in_image, is_read;
  logic [15:0] top_row, bot_row, area;
  logic [CW-1:0] a_tl, a_tr, a_br, a_bl, a_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DIM_RESET;
      height_r <= CFG_DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, above the maximum clamps to it
  always_comb begin
    w_eff = width_r;
    if (width_r == '0) w_eff = 8'd1;
    else if ({4'b0000, width_r} > MAXW) w_eff = MAXW[7:0];
    h_eff = height_r;
    if (height_r == '0) h_eff = 8'd1;
    else if ({4'b0000, height_r} > MAXH) h_eff = MAXH[7:0];
  end

  assign bounds_ok = coord_ok(in_left_x, w_eff) && coord_ok(in_right_x, w_eff) &&
                     coord_ok(in_top_y, h_eff) && coord_ok(in_bottom_y, h_eff);

  assign top_row = {8'b0, in_top_y[7:0]} * {8'b0, w_eff};
  assign bot_row = {8'b0, in_bottom_y[7:0]} * {8'b0, w_eff};
  assign area    = {8'b0, w_eff} * {8'b0, h_eff};

  assign a_tl = CW'(top_row) + CW'(in_left_x[7:0]);
  assign a_tr = CW'(top_row) + CW'(in_right_x[7:0]);
  assign a_br = CW'(bot_row) + CW'(in_right_x[7:0]);
  assign a_bl = CW'(bot_row) + CW'(in_left_x[7:0]);
  assign a_rd = CW'(in_read_pixel);

  assign rd_in_image = {2'b00, in_read_pixel} < area;
  assign is_read     = (in_func == FUNC_READ);
  assign keep_o      = is_read || bounds_ok;

  always_comb begin
    cmd_o.rd       = is_read;
    cmd_o.in_image = is_read ? rd_in_image : 1'b1;
    cmd_o.score[CORNER_TL] = in_score_top_left;
    cmd_o.score[CORNER_TR] = in_score_top_right;
    cmd_o.score[CORNER_BR] = in_score_bottom_right;
    cmd_o.score[CORNER_BL] = in_score_bottom_left;
    // negated flow, saturating the most negative code
    cmd_o.fx = (in_motion_x == FLOW_MIN) ? FLOW_MAX : -in_motion_x;
    cmd_o.fy = (in_motion_y == FLOW_MIN) ? FLOW_MAX : -in_motion_y;
    if (is_read) begin
      addr_o[CORNER_TL] = a_rd[AW-1:0];
      addr_o[CORNER_TR] = a_rd[AW-1:0];
      addr_o[CORNER_BR] = a_rd[AW-1:0];
      addr_o[CORNER_BL] = a_rd[AW-1:0];
    end else begin
      addr_o[CORNER_TL] = a_tl[AW-1:0];
      addr_o[CORNER_TR] = a_tr[AW-1:0];
      addr_o[CORNER_BR] = a_br[AW-1:0];
      addr_o[CORNER_BL] = a_bl[AW-1:0];
    end
  end

endmodule

// ----- design/fims_fifo.sv -----
`timescale 1ns / 1ps
// fims_fifo: two-entry request queue between front and back
// no package dependencies

module fims_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output logic [DW-1:0] dout
);

  localparam logic [1:0] FULL_CNT = 2'd2;

  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full     = (cnt_r == FULL_CNT);
  assign nonempty = (cnt_r != 2'd0);
  assign dout     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != FULL_CNT))
    else $error("request queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != 2'd0))
    else $error("request queue read while empty");
`endif

endmodule

// ----- design/fims_back.sv -----
`timescale 1ns / 1ps
// fims_back: four corner slot banks, clearing pass, splat update and read-out
// depends on fims_pkg

module fims_back #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int AW         = 14
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        q_valid,
  input  fims_pkg::cmd_t                              q_cmd,
  input  logic [fims_pkg::NUM_CORNERS-1:0][AW-1:0]    q_addr,
  output logic                                        pop_o,
  output logic                                        clearing_o,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [1:0]                                  out_corner,
  output logic signed [fims_pkg::FLOW_W-1:0]          out_motion_x,
  output logic signed [fims_pkg::FLOW_W-1:0]          out_motion_y,
  output logic signed [fims_pkg::SCORE_W-1:0]         out_score,
  output logic                                        out_last
);
  import fims_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  state_t  state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  corner_t cnt_r, cnt_nxt;
  cmd_t    cmd_r, cmd_nxt;
  logic [NUM_CORNERS-1:0][AW-1:0] addr_r, addr_nxt;

  logic               re;
  logic [NUM_CORNERS-1:0] we;
  logic [AW-1:0]      waddr [NUM_CORNERS];
  slot_t              wdata [NUM_CORNERS];
  slot_t              rd_data [NUM_CORNERS];
  slot_t              sel;

  for (genvar b = 0; b < NUM_CORNERS; b++) begin : g_bank
    slot_t mem [DEPTH];
    slot_t rd_q_r;
    always_ff @(posedge clk) begin
      if (we[b]) mem[waddr[b]] <= wdata[b];
      if (re) rd_q_r <= mem[q_addr[b]];
    end
    assign rd_data[b] = rd_q_r;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    pop_o     = 1'b0;
    re        = 1'b0;
    we        = '0;
    for (int b = 0; b < NUM_CORNERS; b++) begin
      waddr[b] = addr_r[b];
      wdata[b] = RESET_SLOT;
    end
    unique case (state_r)
      S_CLEAR: begin
        we = '1;
        for (int b = 0; b < NUM_CORNERS; b++) waddr[b] = clr_r;
        if (clr_r == LAST_ADDR) state_nxt = S_IDLE;
        else clr_nxt = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (q_valid) begin
          pop_o     = 1'b1;
          re        = q_cmd.in_image;
          cmd_nxt   = q_cmd;
          addr_nxt  = q_addr;
          cnt_nxt   = CORNER_TL;
          state_nxt = q_cmd.rd ? S_EMIT : S_SPLAT;
        end
      end
      S_SPLAT: begin
        // strictly better score wins the slot
        for (int b = 0; b < NUM_CORNERS; b++) begin
          wdata[b] = '{fx: cmd_r.fx, fy: cmd_r.fy, score: cmd_r.score[b]};
          we[b]    = $signed(cmd_r.score[b]) > $signed(rd_data[b].score);
        end
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        // read data is already latched, so the slots can be reset right away
        if (cmd_r.in_image) we = '1;
        if (!out_stall) begin
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == CORNER_BL) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= CORNER_TL;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    addr_r <= addr_nxt;
  end

  assign clearing_o = (state_r == S_CLEAR);
  assign sel        = cmd_r.in_image ? rd_data[cnt_r] : RESET_SLOT;

  assign out_valid    = (state_r == S_EMIT);
  assign out_corner   = cnt_r;
  assign out_motion_x = sel.fx;
  assign out_motion_y = sel.fy;
  assign out_score    = sel.score;
  assign out_last     = (cnt_r == CORNER_BL);

`ifndef SYNTHESIS
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_o |-> !pop_o)
    else $error("request taken during clearing pass");
  a_readout_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> (state_r == S_IDLE))
    else $error("back end did not return to idle after read-out");
  a_splat_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLAT) |-> $past(pop_o))
    else $error("splat update without a popped request");
`endif

endmodule

// ----- tb/flow_inverse_max_splat_core_test.sv -----
`timescale 1ns / 1ps
// flow_inverse_max_splat_core_test: self-checking bench for the max-score flow splat core
// keeps its own copy of the corner slots and checks every read-out slot in order
// depends on fims_pkg and flow_inverse_max_splat_core

module flow_inverse_max_splat_core_test;
  import fims_pkg::*;

  localparam int MAX_W          = 128;
  localparam int MAX_H          = 128;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 80000;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic                     func;
    coord_t                   lx;
    coord_t                   rx;
    coord_t                   ty;
    coord_t                   by;
    score_t [NUM_CORNERS-1:0] sc;
    flow_t                    mx;
    flow_t                    my;
    logic [PIX_W-1:0]         pix;
  } request_t;

  typedef struct packed {
    corner_t corner;
    flow_t   fx;
    flow_t   fy;
    score_t  score;
    logic    last;
  } readout_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  dim_t                 cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 in_func   = 1'b0;
  coord_t               in_left_x = '0;
  coord_t               in_right_x = '0;
  coord_t               in_top_y = '0;
  coord_t               in_bottom_y = '0;
  score_t               in_score_top_left = '0;
  score_t               in_score_top_right = '0;
  score_t               in_score_bottom_right = '0;
  score_t               in_score_bottom_left = '0;
  flow_t                in_motion_x = '0;
  flow_t                in_motion_y = '0;
  logic [PIX_W-1:0]     in_read_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_corner;
  flow_t                out_motion_x;
  flow_t                out_motion_y;
  score_t               out_score;
  logic                 out_last;

  // predictor state
  slot_t      corner_store [MAX_W*MAX_H][NUM_CORNERS];
  dim_t       width_reg  = CFG_DIM_RESET;
  dim_t       height_reg = CFG_DIM_RESET;
  readout_t   pending_readouts [$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         stall_left  = 0;
  bit         quiet       = 1'b0;

  flow_inverse_max_splat_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_left_x            (in_left_x),
    .in_right_x           (in_right_x),
    .in_top_y             (in_top_y),
    .in_bottom_y          (in_bottom_y),
    .in_score_top_left    (in_score_top_left),
    .in_score_top_right   (in_score_top_right),
    .in_score_bottom_right(in_score_bottom_right),
    .in_score_bottom_left (in_score_bottom_left),
    .in_motion_x          (in_motion_x),
    .in_motion_y          (in_motion_y),
    .in_read_pixel        (in_read_pixel),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_corner           (out_corner),
    .out_motion_x         (out_motion_x),
    .out_motion_y         (out_motion_y),
    .out_score            (out_score),
    .out_last             (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int eff_dim(input dim_t r, input int lim);
    if (r == '0) return 1;
    return (int'(r) > lim) ? lim : int'(r);
  endfunction

  function automatic bit in_span(input coord_t c, input int lim);
    return (int'(c) >= 0) && (int'(c) < lim);
  endfunction

  function automatic flow_t negate_flow(input flow_t m);
    int v;
    v = -int'(m);
    return (v > 32767) ? FLOW_MAX : flow_t'(v);
  endfunction

  task automatic keep_best(input int pix, input corner_t c, input score_t s,
                           input flow_t nfx, input flow_t nfy);
    if (int'(s) > int'(corner_store[pix][c].score))
      corner_store[pix][c] = slot_t'{fx: nfx, fy: nfy, score: s};
  endtask

  task automatic apply_request(input request_t r);
    int    w;
    int    h;
    int    xl;
    int    xr;
    int    yu;
    int    yd;
    int    pix;
    flow_t nfx;
    flow_t nfy;
    slot_t cur;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    if (r.func == FUNC_SPLAT) begin
      xl  = r.lx;
      xr  = r.rx;
      yu  = r.ty;
      yd  = r.by;
      nfx = negate_flow(r.mx);
      nfy = negate_flow(r.my);
      // whole footprint must sit inside the image or nothing changes
      if (in_span(r.lx, w) && in_span(r.rx, w) && in_span(r.ty, h) && in_span(r.by, h)) begin
        keep_best(yu * w + xl, CORNER_TL, r.sc[CORNER_TL], nfx, nfy);
        keep_best(yu * w + xr, CORNER_TR, r.sc[CORNER_TR], nfx, nfy);
        keep_best(yd * w + xr, CORNER_BR, r.sc[CORNER_BR], nfx, nfy);
        keep_best(yd * w + xl, CORNER_BL, r.sc[CORNER_BL], nfx, nfy);
      end
    end else begin
      pix = r.pix;
      for (int c = 0; c < NUM_CORNERS; c++) begin
        if (pix < w * h) begin
          cur = corner_store[pix][c];
          corner_store[pix][c] = RESET_SLOT;
        end else begin
          cur = RESET_SLOT;
        end
        pending_readouts.push_back(readout_t'{corner: corner_t'(c), fx: cur.fx, fy: cur.fy,
                                              score: cur.score,
                                              last: (c == NUM_CORNERS - 1)});
      end
    end
  endtask

  // ---------------------------------------------------------------- request builders

  function automatic score_t rand_score();
    case ($urandom_range(0, 5))
      0: return RESET_SCORE + score_t'($urandom_range(0, 1));
      1: return score_t'(int'($urandom_range(0, 8)) - 4);
      2: return ($urandom_range(0, 1) != 0) ? score_t'(24'h7fffff) : score_t'(24'h800000);
      default: return score_t'($urandom());
    endcase
  endfunction

  function automatic flow_t rand_motion();
    case ($urandom_range(0, 5))
      0: return FLOW_MIN;
      1: return FLOW_MAX;
      default: return flow_t'($urandom());
    endcase
  endfunction

  function automatic request_t read_req(input int p);
    request_t r;
    r        = request_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    r.func   = FUNC_READ;
    r.pix    = PIX_W'(p);
    return r;
  endfunction

  function automatic request_t splat_req(input int lx, input int rx, input int ty,
                                         input int by, input score_t s_tl,
                                         input score_t s_tr, input score_t s_br,
                                         input score_t s_bl, input flow_t mx,
                                         input flow_t my);
    request_t r;
    r               = read_req(int'($urandom_range(0, 16383)));
    r.func          = FUNC_SPLAT;
    r.lx            = coord_t'(lx);
    r.rx            = coord_t'(rx);
    r.ty            = coord_t'(ty);
    r.by            = coord_t'(by);
    r.sc[CORNER_TL] = s_tl;
    r.sc[CORNER_TR] = s_tr;
    r.sc[CORNER_BR] = s_br;
    r.sc[CORNER_BL] = s_bl;
    r.mx            = mx;
    r.my            = my;
    return r;
  endfunction

  // footprint of mostly neighboring pixels with random content; broken ones replace one
  // coordinate with a value that is usually outside the image
  function automatic request_t random_splat(input int w, input int h, input bit broken);
    request_t r;
    int       xl;
    int       yu;
    int       xr;
    int       yd;
    int       which;
    int       lim;
    int       bad;
    xl = $urandom_range(0, w - 1);
    yu = $urandom_range(0, h - 1);
    xr = (xl + 1 < w && $urandom_range(0, 3) != 0) ? xl + 1 : int'($urandom_range(0, w - 1));
    yd = (yu + 1 < h && $urandom_range(0, 3) != 0) ? yu + 1 : int'($urandom_range(0, h - 1));
    r  = splat_req(xl, xr, yu, yd, rand_score(), rand_score(), rand_score(), rand_score(),
                   rand_motion(), rand_motion());
    if (broken) begin
      which = $urandom_range(0, 3);
      lim   = (which < 2) ? w : h;
      case ($urandom_range(0, 2))
        0:       bad = -int'($urandom_range(1, 2048));
        1:       bad = lim + int'($urandom_range(0, 2047 - lim));
        default: bad = int'($urandom_range(0, 4095)) - 2048;
      endcase
      case (which)
        0:       r.lx = coord_t'(bad);
        1:       r.rx = coord_t'(bad);
        2:       r.ty = coord_t'(bad);
        default: r.by = coord_t'(bad);
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_request(input request_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_func               <= r.func;
    in_left_x             <= r.lx;
    in_right_x            <= r.rx;
    in_top_y              <= r.ty;
    in_bottom_y           <= r.by;
    in_score_top_left     <= r.sc[CORNER_TL];
    in_score_top_right    <= r.sc[CORNER_TR];
    in_score_bottom_right <= r.sc[CORNER_BR];
    in_score_bottom_left  <= r.sc[CORNER_BL];
    in_motion_x           <= r.mx;
    in_motion_y           <= r.my;
    in_read_pixel         <= r.pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_request(r);
  endtask

  // splats give no result, so give the back end time to finish the last one
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input dim_t w, input dim_t h);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    width_reg = w;
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < PRINT_LIMIT)
      $display("mismatch in %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    error_count++;
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    readout_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch("result with no request pending", out_corner, -1);
      end else begin
        want = pending_readouts.pop_front();
        if (out_corner !== want.corner) report_mismatch("corner", out_corner, want.corner);
        if (out_motion_x !== want.fx) report_mismatch("motion_x", out_motion_x, want.fx);
        if (out_motion_y !== want.fy) report_mismatch("motion_y", out_motion_y, want.fy);
        if (out_score !== want.score) report_mismatch("score", out_score, want.score);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  // covers the clearing pass after reset with a wide margin
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", idle_cycles);
      $display("flow_inverse_max_splat_core_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_contents();
    send_request(read_req(0));
    send_request(read_req(MAX_W * MAX_H - 1));
  endtask

  task automatic test_best_score();
    set_dims(8'd4, 8'd4);
    // equal score never replaces, min score never beats the reset score
    send_request(splat_req(0, 1, 0, 1, score_t'(24'h7fffff), RESET_SCORE, RESET_SCORE + 24'sd1,
                           score_t'(24'h800000), FLOW_MIN, FLOW_MAX));
    send_request(splat_req(0, 1, 0, 1, score_t'(24'h7fffff), -24'sd1, RESET_SCORE, 24'sd0,
                           16'sd100, -16'sd1));
    send_request(splat_req(3, 3, 3, 3, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 16'sd0, 16'sd0));
    send_request(read_req(0));
    send_request(read_req(1));
    send_request(read_req(4));
    send_request(read_req(5));
    send_request(read_req(15));
    send_request(read_req(16));
    send_request(read_req(MAX_W * MAX_H - 1));
  endtask

  task automatic test_bounds();
    send_request(splat_req(-1, 2, 1, 2, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 16'sd3, 16'sd4));
    send_request(splat_req(1, 4, 1, 2, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 16'sd3, 16'sd4));
    send_request(splat_req(1, 2, -2048, 2, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 16'sd3,
                           16'sd4));
    send_request(splat_req(1, 2, 1, 4, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 16'sd3, 16'sd4));
    send_request(splat_req(2047, 2, 1, 2, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 16'sd3,
                           16'sd4));
    send_request(read_req(5));
    send_request(read_req(10));
  endtask

  task automatic test_dim_limits();
    // zero acts as one pixel
    set_dims(8'd0, 8'd0);
    send_request(splat_req(0, 0, 0, 0, 24'sd1, 24'sd2, 24'sd3, 24'sd4, 16'sd7, -16'sd7));
    send_request(splat_req(1, 0, 0, 0, 24'sd9, 24'sd9, 24'sd9, 24'sd9, 16'sd1, 16'sd1));
    send_request(read_req(0));
    send_request(read_req(1));
    // above the maximum acts as the maximum
    set_dims(8'd255, 8'd200);
    send_request(splat_req(126, 127, 126, 127, 24'sd9, 24'sd9, 24'sd9, 24'sd9, FLOW_MIN,
                           FLOW_MIN));
    send_request(read_req(MAX_W * MAX_H - 1));
  endtask

  task automatic test_random_images();
    int w;
    int h;
    for (int img = 0; img < 6; img++) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      set_dims(dim_t'(w), dim_t'(h));
      repeat ($urandom_range(4, 10))
        send_request(random_splat(w, h, $urandom_range(0, 5) == 0));
      for (int p = 0; p < w * h; p++) send_request(read_req(p));
      send_request(read_req(w * h + int'($urandom_range(0, 40))));
    end
  endtask

  task automatic test_wild_requests();
    request_t r;
    set_dims(8'd128, 8'd128);
    repeat (25) begin
      case ($urandom_range(0, 2))
        0: begin
          r    = random_splat(MAX_W, MAX_H, 1'b0);
          r.lx = coord_t'($urandom());
          r.rx = coord_t'($urandom());
          r.ty = coord_t'($urandom());
          r.by = coord_t'($urandom());
        end
        1:       r = random_splat(MAX_W, MAX_H, 1'b0);
        default: r = read_req(int'($urandom_range(0, 16383)));
      endcase
      send_request(r);
    end
  endtask

  task automatic test_steady_stream();
    quiet = 1'b1;
    set_dims(8'd3, 8'd2);
    repeat (6) send_request(random_splat(3, 2, 1'b0));
    for (int p = 0; p < 6; p++) send_request(read_req(p));
  endtask

  initial begin
    for (int p = 0; p < MAX_W * MAX_H; p++)
      for (int c = 0; c < NUM_CORNERS; c++) corner_store[p][c] = RESET_SLOT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_contents();
    test_best_score();
    test_bounds();
    test_dim_limits();
    test_random_images();
    test_wild_requests();
    test_steady_stream();
    settle_block();
    if (error_count == 0) begin
      $display("flow_inverse_max_splat_core_test passed");
    end else begin
      $display("flow_inverse_max_splat_core_test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/fims_pkg.sv
design/fims_front.sv
design/fims_fifo.sv
design/fims_back.sv
design/flow_inverse_max_splat_core.sv
tb/flow_inverse_max_splat_core_test.sv
